/* src/dtp_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// dtp_pkg
// Shared types, constants, the character classifier, the unit scale table
// and the microcode store of the duration text parser.
// ============================================================================
package dtp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_LC_M  = 8'h6D;
    localparam logic [7:0] CHAR_LC_S  = 8'h73;
    localparam logic [7:0] CHAR_LC_H  = 8'h68;
    localparam logic [7:0] CHAR_LC_D  = 8'h64;
    localparam logic [7:0] CHAR_LC_W  = 8'h77;
    localparam logic [7:0] CHAR_LC_Y  = 8'h79;

    // Datapath widths
    localparam int unsigned TOTAL_W     = 64;
    localparam int unsigned HALF_W      = 32;
    localparam int unsigned FRAC_W      = 60;    // fraction stays below 10^18
    localparam int unsigned SCALE_W     = 36;    // one year in ms needs 35 bits
    localparam int unsigned CNT_W       = 5;
    localparam int unsigned UNIT_COUNT  = 8;
    localparam int unsigned QUOT_DEPTH  = 16;
    localparam logic [CNT_W-1:0] MAX_FRACTION_DIGITS = 5'd18;

    // Microcode addresses
    localparam int unsigned ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_FETCH  = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_DECODE = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_DIGIT  = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_DOT    = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_SETM   = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_SIGN   = 4'd5;
    localparam logic [ADDR_W-1:0] ADDR_CLEAR  = 4'd6;
    localparam logic [ADDR_W-1:0] ADDR_EMIT   = 4'd7;
    localparam logic [ADDR_W-1:0] ADDR_CLOSE0 = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_CLOSE1 = 4'd9;
    localparam logic [ADDR_W-1:0] ADDR_CLOSE2 = 4'd10;
    localparam logic [ADDR_W-1:0] ADDR_CLOSE3 = 4'd11;
    localparam logic [ADDR_W-1:0] ADDR_CLOSE4 = 4'd12;
    localparam logic [ADDR_W-1:0] ADDR_CLOSE5 = 4'd13;
    localparam logic [ADDR_W-1:0] ADDR_CLOSE6 = 4'd14;

    typedef enum logic [2:0] {
        UNIT_NONE, UNIT_MS, UNIT_SEC, UNIT_MIN,
        UNIT_HOUR, UNIT_DAY, UNIT_WEEK, UNIT_YEAR
    } unit_t;

    typedef enum logic [3:0] {
        CLS_DIGIT, CLS_DOT, CLS_M, CLS_S, CLS_H, CLS_D,
        CLS_W, CLS_Y, CLS_PLUS, CLS_MINUS, CLS_OTHER
    } char_class_t;

    typedef enum logic [2:0] {
        JMP_NEXT, JMP_GOTO, JMP_WAIT_IN, JMP_DISPATCH, JMP_RETURN, JMP_WAIT_OUT
    } jump_t;

    typedef enum logic [2:0] {
        OP_NONE, OP_DECODE, OP_DIGIT, OP_DOT, OP_SETM, OP_SIGN, OP_CLEAR, OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        A_WHOLE_LO, A_WHOLE_HI, A_FRAC_LO, A_FRAC_HI
    } a_sel_t;

    typedef enum logic [1:0] {
        B_UNIT_LO, B_UNIT_HI, B_QUOT_LO, B_QUOT_HI
    } b_sel_t;

    // One microcode word
    typedef struct packed {
        jump_t             jump;
        logic [ADDR_W-1:0] target;
        logic              in_ready;
        op_t               op;
        logic              mul_en;
        a_sel_t            a_sel;
        b_sel_t            b_sel;
        logic              acc_en;
        logic              acc_hi;
        logic              clr_num;
    } ucode_t;

    // Sequencer to datapath
    typedef struct packed {
        logic   in_load;
        op_t    op;
        logic   mul_en;
        a_sel_t a_sel;
        b_sel_t b_sel;
        logic   acc_en;
        logic   acc_hi;
        logic   clr_num;
        unit_t  unit;
    } dp_ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        char_class_t cls;
        logic        end_flag;
        logic        at_start;
        logic        pending;
        logic        out_free;
    } dp_stat_t;

    // unit_ms / 10^n per unit; column 0 is the unit itself
    localparam logic [SCALE_W-1:0] QUOT_TABLE [UNIT_COUNT][QUOT_DEPTH] = '{
        '{default: 36'd0},
        '{0: 36'd1, default: 36'd0},
        '{0: 36'd1000, 1: 36'd100, 2: 36'd10, 3: 36'd1, default: 36'd0},
        '{0: 36'd60000, 1: 36'd6000, 2: 36'd600, 3: 36'd60, 4: 36'd6,
          default: 36'd0},
        '{0: 36'd3600000, 1: 36'd360000, 2: 36'd36000, 3: 36'd3600,
          4: 36'd360, 5: 36'd36, 6: 36'd3, default: 36'd0},
        '{0: 36'd86400000, 1: 36'd8640000, 2: 36'd864000, 3: 36'd86400,
          4: 36'd8640, 5: 36'd864, 6: 36'd86, 7: 36'd8, default: 36'd0},
        '{0: 36'd604800000, 1: 36'd60480000, 2: 36'd6048000, 3: 36'd604800,
          4: 36'd60480, 5: 36'd6048, 6: 36'd604, 7: 36'd60, 8: 36'd6,
          default: 36'd0},
        '{0: 36'd31536000000, 1: 36'd3153600000, 2: 36'd315360000,
          3: 36'd31536000, 4: 36'd3153600, 5: 36'd315360, 6: 36'd31536,
          7: 36'd3153, 8: 36'd315, 9: 36'd31, 10: 36'd3, default: 36'd0}
    };

    function automatic logic [SCALE_W-1:0] unit_scale(unit_t u, logic [CNT_W-1:0] n);
        logic [SCALE_W-1:0] val;
        val = '0;
        if (n < CNT_W'(QUOT_DEPTH)) begin
            val = QUOT_TABLE[u][n[3:0]];
        end
        return val;
    endfunction

    function automatic char_class_t classify(logic [7:0] c);
        char_class_t cls;
        case (c) inside
            [CHAR_ZERO:CHAR_NINE]: cls = CLS_DIGIT;
            CHAR_DOT:              cls = CLS_DOT;
            CHAR_LC_M:             cls = CLS_M;
            CHAR_LC_S:             cls = CLS_S;
            CHAR_LC_H:             cls = CLS_H;
            CHAR_LC_D:             cls = CLS_D;
            CHAR_LC_W:             cls = CLS_W;
            CHAR_LC_Y:             cls = CLS_Y;
            CHAR_PLUS:             cls = CLS_PLUS;
            CHAR_MINUS:            cls = CLS_MINUS;
            default:               cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    // Microcode store
    function automatic ucode_t ucode_rom(logic [ADDR_W-1:0] addr);
        ucode_t w;
        w        = '0;
        w.jump   = JMP_GOTO;
        w.target = ADDR_FETCH;
        w.op     = OP_NONE;
        case (addr)
            ADDR_FETCH: begin
                w.in_ready = 1'b1;
                w.jump     = JMP_WAIT_IN;
                w.target   = ADDR_DECODE;
            end
            ADDR_DECODE: begin
                w.op   = OP_DECODE;
                w.jump = JMP_DISPATCH;
            end
            ADDR_DIGIT: w.op = OP_DIGIT;
            ADDR_DOT:   w.op = OP_DOT;
            ADDR_SETM:  w.op = OP_SETM;
            ADDR_SIGN:  w.op = OP_SIGN;
            ADDR_CLEAR: w.op = OP_CLEAR;
            ADDR_EMIT: begin
                w.op   = OP_EMIT;
                w.jump = JMP_WAIT_OUT;
            end
            ADDR_CLOSE0: begin
                w.jump   = JMP_NEXT;
                w.mul_en = 1'b1;
                w.a_sel  = A_WHOLE_LO;
                w.b_sel  = B_UNIT_LO;
            end
            ADDR_CLOSE1: begin
                w.jump   = JMP_NEXT;
                w.mul_en = 1'b1;
                w.a_sel  = A_WHOLE_HI;
                w.b_sel  = B_UNIT_LO;
                w.acc_en = 1'b1;
            end
            ADDR_CLOSE2: begin
                w.jump   = JMP_NEXT;
                w.mul_en = 1'b1;
                w.a_sel  = A_WHOLE_LO;
                w.b_sel  = B_UNIT_HI;
                w.acc_en = 1'b1;
                w.acc_hi = 1'b1;
            end
            ADDR_CLOSE3: begin
                w.jump   = JMP_NEXT;
                w.mul_en = 1'b1;
                w.a_sel  = A_FRAC_LO;
                w.b_sel  = B_QUOT_LO;
                w.acc_en = 1'b1;
                w.acc_hi = 1'b1;
            end
            ADDR_CLOSE4: begin
                w.jump   = JMP_NEXT;
                w.mul_en = 1'b1;
                w.a_sel  = A_FRAC_HI;
                w.b_sel  = B_QUOT_LO;
                w.acc_en = 1'b1;
            end
            ADDR_CLOSE5: begin
                w.jump   = JMP_NEXT;
                w.mul_en = 1'b1;
                w.a_sel  = A_FRAC_LO;
                w.b_sel  = B_QUOT_HI;
                w.acc_en = 1'b1;
                w.acc_hi = 1'b1;
            end
            ADDR_CLOSE6: begin
                w.jump    = JMP_RETURN;
                w.acc_en  = 1'b1;
                w.acc_hi  = 1'b1;
                w.clr_num = 1'b1;
            end
            default: w.jump = JMP_GOTO;
        endcase
        return w;
    endfunction

endpackage

/* src/dtp_sequencer.sv */
`timescale 1ns / 1ps
// ============================================================================
// dtp_sequencer
// Step counter over the microcode store, with the character dispatch and
// the return flag of the shared number-close routine.
// ============================================================================
module dtp_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dtp_pkg::dp_stat_t stat,
    output dtp_pkg::dp_ctl_t  ctl
);

    logic [dtp_pkg::ADDR_W-1:0] pc_reg, pc_next;
    dtp_pkg::unit_t             unit_reg, unit_next;
    logic                       cont_reg, cont_next;
    dtp_pkg::ucode_t            word;
    logic                       accept;
    logic [dtp_pkg::ADDR_W-1:0] disp_target;
    dtp_pkg::unit_t             disp_unit;
    logic                       disp_cont;

    assign word    = dtp_pkg::ucode_rom(pc_reg);
    assign s_ready = word.in_ready;
    assign accept  = word.in_ready & s_valid;

    // Pick the routine for the latched beat
    always_comb begin
        disp_target = dtp_pkg::ADDR_FETCH;
        disp_unit   = dtp_pkg::UNIT_NONE;
        disp_cont   = 1'b0;
        if (stat.end_flag) begin
            if (stat.pending) begin
                disp_target = dtp_pkg::ADDR_CLOSE0;
                disp_unit   = dtp_pkg::UNIT_MIN;
                disp_cont   = 1'b1;
            end else begin
                disp_target = dtp_pkg::ADDR_EMIT;
            end
        end else if (stat.at_start &&
                     (stat.cls == dtp_pkg::CLS_PLUS || stat.cls == dtp_pkg::CLS_MINUS)) begin
            disp_target = dtp_pkg::ADDR_SIGN;
        end else if (stat.pending) begin
            disp_target = dtp_pkg::ADDR_CLOSE0;
            if (stat.cls == dtp_pkg::CLS_S) begin
                disp_unit = dtp_pkg::UNIT_MS;
            end else begin
                disp_unit = dtp_pkg::UNIT_MIN;
                disp_cont = 1'b1;
            end
        end else begin
            case (stat.cls)
                dtp_pkg::CLS_DIGIT: disp_target = dtp_pkg::ADDR_DIGIT;
                dtp_pkg::CLS_DOT:   disp_target = dtp_pkg::ADDR_DOT;
                dtp_pkg::CLS_M:     disp_target = dtp_pkg::ADDR_SETM;
                dtp_pkg::CLS_S: begin
                    disp_target = dtp_pkg::ADDR_CLOSE0;
                    disp_unit   = dtp_pkg::UNIT_SEC;
                end
                dtp_pkg::CLS_H: begin
                    disp_target = dtp_pkg::ADDR_CLOSE0;
                    disp_unit   = dtp_pkg::UNIT_HOUR;
                end
                dtp_pkg::CLS_D: begin
                    disp_target = dtp_pkg::ADDR_CLOSE0;
                    disp_unit   = dtp_pkg::UNIT_DAY;
                end
                dtp_pkg::CLS_W: begin
                    disp_target = dtp_pkg::ADDR_CLOSE0;
                    disp_unit   = dtp_pkg::UNIT_WEEK;
                end
                dtp_pkg::CLS_Y: begin
                    disp_target = dtp_pkg::ADDR_CLOSE0;
                    disp_unit   = dtp_pkg::UNIT_YEAR;
                end
                default: disp_target = dtp_pkg::ADDR_CLEAR;
            endcase
        end
    end

    // Next step
    always_comb begin
        unit_next = unit_reg;
        cont_next = cont_reg;
        case (word.jump)
            dtp_pkg::JMP_NEXT:     pc_next = pc_reg + dtp_pkg::ADDR_W'(1);
            dtp_pkg::JMP_GOTO:     pc_next = word.target;
            dtp_pkg::JMP_WAIT_IN:  pc_next = accept ? word.target : pc_reg;
            dtp_pkg::JMP_DISPATCH: begin
                pc_next   = disp_target;
                unit_next = disp_unit;
                cont_next = disp_cont;
            end
            dtp_pkg::JMP_RETURN:
                pc_next = cont_reg ? dtp_pkg::ADDR_DECODE : dtp_pkg::ADDR_FETCH;
            dtp_pkg::JMP_WAIT_OUT: pc_next = stat.out_free ? word.target : pc_reg;
            default:               pc_next = dtp_pkg::ADDR_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= dtp_pkg::ADDR_FETCH;
            unit_reg <= dtp_pkg::UNIT_NONE;
            cont_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            unit_reg <= unit_next;
            cont_reg <= cont_next;
        end
    end

    always_comb begin
        ctl.in_load = accept;
        ctl.op      = word.op;
        ctl.mul_en  = word.mul_en;
        ctl.a_sel   = word.a_sel;
        ctl.b_sel   = word.b_sel;
        ctl.acc_en  = word.acc_en;
        ctl.acc_hi  = word.acc_hi;
        ctl.clr_num = word.clr_num;
        ctl.unit    = unit_reg;
    end

endmodule

/* src/dtp_datapath.sv */
`timescale 1ns / 1ps
// ============================================================================
// dtp_datapath
// Parse state, digit accumulators, shared 32x32 multiplier with running
// total, and the result output register.
// ============================================================================
module dtp_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dtp_pkg::dp_ctl_t            ctl,
    output dtp_pkg::dp_stat_t           stat,
    input  logic [7:0]                  s_text_byte,
    input  logic                        s_end_marker,
    output logic signed [63:0]          m_duration_ms,
    output logic                        m_valid,
    input  logic                        m_ready
);

    localparam int unsigned TW = dtp_pkg::TOTAL_W;
    localparam int unsigned HW = dtp_pkg::HALF_W;
    localparam int unsigned FW = dtp_pkg::FRAC_W;
    localparam int unsigned SW = dtp_pkg::SCALE_W;
    localparam int unsigned CW = dtp_pkg::CNT_W;

    logic [7:0]    byte_reg;
    logic          end_reg;
    logic          at_start_reg, at_start_next;
    logic          neg_reg, neg_next;
    logic          frac_mode_reg, frac_mode_next;
    logic          pending_reg, pending_next;
    logic [TW-1:0] whole_reg, whole_next;
    logic [FW-1:0] frac_reg, frac_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [TW-1:0] total_reg, total_next;
    logic [TW-1:0] mul_reg;
    logic [TW-1:0] out_data_reg;
    logic          out_valid_reg, out_valid_next;

    logic          out_free;
    logic [3:0]    digit;
    logic [SW-1:0] unit_ms;
    logic [SW-1:0] quot;
    logic [HW-1:0] a_op;
    logic [HW-1:0] b_op;
    logic [TW-1:0] product;
    logic [TW-1:0] addend;

    assign out_free = !out_valid_reg || m_ready;
    assign digit    = byte_reg[3:0];
    assign unit_ms  = dtp_pkg::unit_scale(ctl.unit, '0);
    assign quot     = dtp_pkg::unit_scale(ctl.unit, cnt_reg);

    // Multiplier operands
    always_comb begin
        case (ctl.a_sel)
            dtp_pkg::A_WHOLE_LO: a_op = whole_reg[HW-1:0];
            dtp_pkg::A_WHOLE_HI: a_op = whole_reg[TW-1:HW];
            dtp_pkg::A_FRAC_LO:  a_op = frac_reg[HW-1:0];
            dtp_pkg::A_FRAC_HI:  a_op = HW'(frac_reg[FW-1:HW]);
            default:             a_op = '0;
        endcase
        case (ctl.b_sel)
            dtp_pkg::B_UNIT_LO: b_op = unit_ms[HW-1:0];
            dtp_pkg::B_UNIT_HI: b_op = HW'(unit_ms[SW-1:HW]);
            dtp_pkg::B_QUOT_LO: b_op = quot[HW-1:0];
            dtp_pkg::B_QUOT_HI: b_op = HW'(quot[SW-1:HW]);
            default:            b_op = '0;
        endcase
    end

    assign product = {{HW{1'b0}}, a_op} * {{HW{1'b0}}, b_op};
    assign addend  = ctl.acc_hi ? {mul_reg[HW-1:0], {HW{1'b0}}} : mul_reg;

    always_comb begin
        at_start_next  = at_start_reg;
        neg_next       = neg_reg;
        frac_mode_next = frac_mode_reg;
        pending_next   = pending_reg;
        whole_next     = whole_reg;
        frac_next      = frac_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (ctl.acc_en) begin
            total_next = total_reg + addend;
        end

        if (ctl.clr_num) begin
            frac_mode_next = 1'b0;
            pending_next   = 1'b0;
            whole_next     = '0;
            frac_next      = '0;
            cnt_next       = '0;
        end

        case (ctl.op)
            dtp_pkg::OP_DECODE: begin
                if (!end_reg) begin
                    at_start_next = 1'b0;
                end
            end
            dtp_pkg::OP_DIGIT: begin
                if (frac_mode_reg) begin
                    // drop digits past the fraction limit
                    if (cnt_reg < dtp_pkg::MAX_FRACTION_DIGITS) begin
                        frac_next = {frac_reg[FW-4:0], 3'b000} + {frac_reg[FW-2:0], 1'b0}
                                  + FW'(digit);
                        cnt_next  = cnt_reg + CW'(1);
                    end
                end else begin
                    whole_next = {whole_reg[TW-4:0], 3'b000} + {whole_reg[TW-2:0], 1'b0}
                               + TW'(digit);
                end
            end
            dtp_pkg::OP_DOT: begin
                if (frac_mode_reg) begin
                    whole_next = '0;
                    frac_next  = '0;
                    cnt_next   = '0;
                end
                frac_mode_next = 1'b1;
            end
            dtp_pkg::OP_SETM: pending_next = 1'b1;
            dtp_pkg::OP_SIGN: neg_next = (stat.cls == dtp_pkg::CLS_MINUS);
            dtp_pkg::OP_CLEAR: begin
                frac_mode_next = 1'b0;
                pending_next   = 1'b0;
                whole_next     = '0;
                frac_next      = '0;
                cnt_next       = '0;
            end
            dtp_pkg::OP_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    at_start_next  = 1'b1;
                    neg_next       = 1'b0;
                    frac_mode_next = 1'b0;
                    pending_next   = 1'b0;
                    whole_next     = '0;
                    frac_next      = '0;
                    cnt_next       = '0;
                    total_next     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg  <= 1'b1;
            neg_reg       <= 1'b0;
            frac_mode_reg <= 1'b0;
            pending_reg   <= 1'b0;
            whole_reg     <= '0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            at_start_reg  <= at_start_next;
            neg_reg       <= neg_next;
            frac_mode_reg <= frac_mode_next;
            pending_reg   <= pending_next;
            whole_reg     <= whole_next;
            frac_reg      <= frac_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctl.in_load) begin
            byte_reg <= s_text_byte;
            end_reg  <= s_end_marker;
        end
        if (ctl.mul_en) begin
            mul_reg <= product;
        end
        if (ctl.op == dtp_pkg::OP_EMIT && out_free) begin
            out_data_reg <= neg_reg ? (TW'(0) - total_reg) : total_reg;
        end
    end

    always_comb begin
        stat.cls      = dtp_pkg::classify(byte_reg);
        stat.end_flag = end_reg;
        stat.at_start = at_start_reg;
        stat.pending  = pending_reg;
        stat.out_free = out_free;
    end

    assign m_duration_ms = $signed(out_data_reg);
    assign m_valid       = out_valid_reg;

endmodule

/* src/duration_text_parser.sv */
`timescale 1ns / 1ps
// ============================================================================
// duration_text_parser
// Parses duration text such as -1h30m or 1.5d250ms into signed milliseconds.
// ============================================================================
// Input channel (s_*): one beat per character on s_text_byte; a beat with
// s_end_marker high closes the text and its byte is ignored. Output channel
// (m_*): one beat per closed text, m_duration_ms as a 64-bit two's
// complement value that wraps on overflow.
//
// Each beat runs as a short microprogram: fetch, decode, then the routine
// for its character. Digits, '.', sign, 'm' and unknown bytes need no
// multiply. A unit character (s, h, d, w, y, or 's' after 'm') closes the
// number: a 7-step multiply-accumulate through one shared 32x32 multiplier
// (whole * unit, then fraction * unit / 10^digits, as three partial
// products each). Any other byte that follows a pending 'm' first closes
// the minutes and is then decoded again. The end beat goes through fetch,
// decode and the emit step to the output register, with the minutes closed
// first when an 'm' is pending.
// s_ready is high only in the fetch step, so one beat is in work at a time.
//
// Reset (aresetn low, synchronous) clears the parse state and the running
// total and drops any result in the output register; no clearing pass.
// A result waits in the output register while m_ready is low and the next
// text is parsed meanwhile; only the following end beat holds in its emit
// step until the register is free.
// ============================================================================
module duration_text_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_text_byte,
    input  logic               s_end_marker,
    input  logic               s_valid,
    output logic               s_ready,
    output logic signed [63:0] m_duration_ms,
    output logic               m_valid,
    input  logic               m_ready
);

    dtp_pkg::dp_ctl_t  ctl;
    dtp_pkg::dp_stat_t stat;

    // Step counter, microcode store and character dispatch
    dtp_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // Accumulators, multiplier, running total and output register
    dtp_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .stat          (stat),
        .s_text_byte   (s_text_byte),
        .s_end_marker  (s_end_marker),
        .m_duration_ms (m_duration_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule

/* src/dtp_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// dtp_checker
// Port-level checks on the duration text parser, bound to its top level.
// ============================================================================
module dtp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic [7:0]         s_text_byte,
    input logic               s_end_marker,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [63:0] m_duration_ms,
    input logic               m_valid,
    input logic               m_ready
);

    // No result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // One beat in work at a time: ready drops after every accepted beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready held after an accepted beat");

    // A stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_duration_ms)))
        else $error("stalled result dropped or changed");

    // A result is emitted only from the emit step, never while fetching
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result emitted in the fetch step");

endmodule

bind duration_text_parser dtp_checker u_dtp_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb - duration_text_parser testbench
// Streams duration texts into the parser byte by byte, each closed by an end
// beat, and predicts every signed millisecond total. Directed texts come
// first: sign handling, pending 'm', unknown bytes and a repeated dot. The
// random texts that follow are mostly well-formed numbers with units, and
// some carry long digit runs or random noise. The sender idles and the
// receiver stalls at changing rates, and one long receiver hold-off fills
// the block until it blocks its input.
// ============================================================================
module tb;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned RANDOM_BEATS  = 1000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam logic [63:0] MS_PER_SEC  = 64'd1000;
    localparam logic [63:0] MS_PER_MIN  = 64'd60000;
    localparam logic [63:0] MS_PER_HOUR = 64'd3600000;
    localparam logic [63:0] MS_PER_DAY  = 64'd86400000;
    localparam logic [63:0] MS_PER_WEEK = 64'd604800000;
    localparam logic [63:0] MS_PER_YEAR = 64'd31536000000;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the parse state of the text in flight and holds the
    // totals expected on the result channel, oldest first.
    // ------------------------------------------------------------------------
    class duration_tally;
        logic               fresh_text;
        logic               minus_seen;
        logic               in_frac;
        logic               m_held;
        logic [63:0]        whole_val;
        logic [63:0]        frac_val;
        int unsigned        frac_digits;
        logic [63:0]        sum_ms;
        logic signed [63:0] expected_ms[$];
        int unsigned        failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void clear_number();
            in_frac     = 1'b0;
            m_held      = 1'b0;
            whole_val   = '0;
            frac_val    = '0;
            frac_digits = 0;
        endfunction

        function void restart();
            fresh_text = 1'b1;
            minus_seen = 1'b0;
            sum_ms     = '0;
            clear_number();
        endfunction

        // Fold the open number into the sum; the fraction scales by the unit
        // divided by 10^digits, truncated.
        function void close_number(logic [63:0] unit_ms);
            logic [63:0] add;
            logic [63:0] p10;
            add = whole_val * unit_ms;
            p10 = 64'd1;
            for (int k = 0; k < frac_digits; k++) p10 = p10 * 64'd10;
            if (frac_val != 0) add = add + frac_val * (unit_ms / p10);
            sum_ms = sum_ms + add;
            clear_number();
        endfunction

        function void absorb_char(logic [7:0] ch);
            if (fresh_text) begin
                fresh_text = 1'b0;
                if (ch == dtp_pkg::CHAR_MINUS || ch == dtp_pkg::CHAR_PLUS) begin
                    minus_seen = (ch == dtp_pkg::CHAR_MINUS);
                    return;
                end
            end
            if (m_held) begin
                if (ch == dtp_pkg::CHAR_LC_S) begin
                    close_number(64'd1);
                    return;
                end
                close_number(MS_PER_MIN);
            end
            if (ch >= dtp_pkg::CHAR_ZERO && ch <= dtp_pkg::CHAR_NINE) begin
                if (!in_frac) begin
                    whole_val = whole_val * 64'd10 + 64'(ch - dtp_pkg::CHAR_ZERO);
                end else if (frac_digits < int'(dtp_pkg::MAX_FRACTION_DIGITS)) begin
                    frac_val = frac_val * 64'd10 + 64'(ch - dtp_pkg::CHAR_ZERO);
                    frac_digits++;
                end
                return;
            end
            case (ch)
                dtp_pkg::CHAR_DOT: begin
                    if (in_frac) close_number(64'd0);
                    in_frac = 1'b1;
                end
                dtp_pkg::CHAR_LC_M: m_held = 1'b1;
                dtp_pkg::CHAR_LC_S: close_number(MS_PER_SEC);
                dtp_pkg::CHAR_LC_H: close_number(MS_PER_HOUR);
                dtp_pkg::CHAR_LC_D: close_number(MS_PER_DAY);
                dtp_pkg::CHAR_LC_W: close_number(MS_PER_WEEK);
                dtp_pkg::CHAR_LC_Y: close_number(MS_PER_YEAR);
                default:            close_number(64'd0);
            endcase
        endfunction

        // Note one accepted input beat.
        function void absorb_beat(logic [7:0] ch, logic last);
            if (!last) begin
                absorb_char(ch);
            end else begin
                close_number(m_held ? MS_PER_MIN : 64'd0);
                expected_ms.push_back(minus_seen ? -sum_ms : sum_ms);
                restart();
            end
        endfunction

        // Check one accepted result beat against the oldest total.
        function void match_duration(logic signed [63:0] got);
            logic signed [63:0] want;
            if (expected_ms.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result beat: got %0d", got);
                return;
            end
            want = expected_ms.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("duration mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic [7:0]         s_text_byte   = '0;
    logic               s_end_marker  = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic signed [63:0] m_duration_ms;
    logic               m_valid;
    logic               m_ready       = 1'b0;

    duration_tally tally = new();

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_go        = 1'b0;
    int unsigned cycle_count    = 0;
    int unsigned beats_sent     = 0;
    logic [7:0]  text_buf[$];

    duration_text_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_text_byte   (s_text_byte),
        .s_end_marker  (s_end_marker),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_duration_ms (m_duration_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

    always #5 aclk = ~aclk;

    // Count cycles and end the run if it hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Sample both handshakes at the edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) tally.absorb_beat(s_text_byte, s_end_marker);
        if (aresetn && m_valid && m_ready) tally.match_duration(m_duration_ms);
    end

    // Receiver: stall at the current rate; once asked, hold off for a long
    // stretch so the result register fills and the parser stalls its input.
    always @(posedge aclk) begin
        static logic        hold_used = 1'b0;
        static int unsigned hold_left = 0;
        if (hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one beat, idling first at the current rate; return at acceptance.
    task automatic push_beat(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_text_byte  <= ch;
        s_end_marker <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    // Send the buffered text, then an end beat carrying the given byte.
    task automatic send_text(input logic [7:0] end_byte);
        foreach (text_buf[i]) push_beat(text_buf[i], 1'b0);
        push_beat(end_byte, 1'b1);
        text_buf.delete();
    endtask

    task automatic append_string(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic append_digits(input int unsigned n);
        repeat (n) text_buf.push_back(dtp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    endtask

    // Build one random text: mostly sequences of numbers with units, some signed,
    // sometimes long digit runs (wrap, long fraction) and stray bytes.
    task automatic compose_text();
        int unsigned pick;
        int unsigned count;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // pure noise over the whole byte range
            repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(255)));
            return;
        end
        if (pick < 25) text_buf.push_back(dtp_pkg::CHAR_MINUS);
        else if (pick < 35) text_buf.push_back(dtp_pkg::CHAR_PLUS);
        count = $urandom_range(1, 4);
        repeat (count) begin
            append_digits(($urandom_range(9) == 0) ? $urandom_range(10, 22)
                                                   : $urandom_range(0, 4));
            if ($urandom_range(2) == 0) begin
                text_buf.push_back(dtp_pkg::CHAR_DOT);
                append_digits(($urandom_range(7) == 0) ? $urandom_range(15, 24)
                                                       : $urandom_range(0, 4));
            end
            case ($urandom_range(9))
                0: append_string("ms");
                1: text_buf.push_back(dtp_pkg::CHAR_LC_M);
                2: text_buf.push_back(dtp_pkg::CHAR_LC_S);
                3: text_buf.push_back(dtp_pkg::CHAR_LC_H);
                4: text_buf.push_back(dtp_pkg::CHAR_LC_D);
                5: text_buf.push_back(dtp_pkg::CHAR_LC_W);
                6: text_buf.push_back(dtp_pkg::CHAR_LC_Y);
                7: text_buf.push_back(dtp_pkg::CHAR_DOT);
                8: append_string("mm");
                default: ;
            endcase
            if ($urandom_range(19) == 0) text_buf.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int unsigned phase;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: sign and minutes at the end, m followed by s, then a
        // leading plus, a bare pending m, unknown bytes, a repeated dot and
        // a sign that is not first.
        append_string("-1h3m");
        send_text(8'h00);
        append_string("1.5d2ms");
        send_text(8'hFF);
        append_string("+m");
        text_buf.push_back(8'hFF);
        append_string("2w.5y1..5s");
        text_buf.push_back(8'h00);
        text_buf.push_back(dtp_pkg::CHAR_MINUS);
        send_text(8'hA5);

        // Random texts across four idling phases; the long hold-off falls
        // in the first, where the sender never idles.
        beats_sent = 0;
        hold_go    = 1'b1;
        while (beats_sent < RANDOM_BEATS) begin
            phase = beats_sent * 4 / RANDOM_BEATS;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            compose_text();
            send_text(8'($urandom_range(255)));
        end
        s_valid <= 1'b0;

        // Drain the remaining totals, then let the block settle.
        while (tally.expected_ms.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tally.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/dtp_pkg.sv
src/dtp_sequencer.sv
src/dtp_datapath.sv
src/duration_text_parser.sv
src/dtp_checker.sv
tb/sv/tb.sv
